// ===== src/lcc_pkg.sv =====
// ---------------------------------------------------------------------------
// lcc_pkg: shared types and constants for the 2D Lloyd clustering block
// Sizes, widths, config register indices, the sequencer state encoding and the divider request.
// ---------------------------------------------------------------------------
package lcc_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 16;
    localparam int COORD_WIDTH  = 16;

    localparam int PADDR_W = $clog2(MAX_POINTS);
    localparam int PCNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CIDX_W  = $clog2(MAX_CLUSTERS);
    localparam int CCNT_W  = $clog2(MAX_CLUSTERS + 1);
    localparam int SUM_W   = COORD_WIDTH + PCNT_W;
    localparam int DIST_W  = 2 * COORD_WIDTH + 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_COUNT = 1'd1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SEED,
        ST_ASSIGN,
        ST_ACCUM,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DIV_WAIT,
        ST_DIV_WRITE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                   start;
        logic signed [SUM_W-1:0] dividend;
        logic [PCNT_W-1:0]      divisor;
    } t_div_req;

endpackage

// ===== src/lcc_divider.sv =====
// ---------------------------------------------------------------------------
// lcc_divider: sequential signed divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ---------------------------------------------------------------------------
module lcc_divider (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lcc_pkg::t_div_req                    i_req,
    output logic                                 o_done,
    output logic signed [lcc_pkg::SUM_W-1:0]     o_quotient
);

    localparam int W   = lcc_pkg::SUM_W;
    localparam int CW  = $clog2(W + 1);

    logic [W-1:0]            r_rem, n_rem;
    logic [W-1:0]            r_quo, n_quo;
    logic [W-1:0]            r_den;
    logic                    r_neg;
    logic [CW-1:0]           r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic [W:0]              w_trial;

    always_comb begin
        w_trial = {r_rem, r_quo[W-1]} - {1'b0, r_den};
        if (!w_trial[W]) begin
            n_rem = w_trial[W-1:0];
            n_quo = {r_quo[W-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[W-2:0], r_quo[W-1]};
            n_quo = {r_quo[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[W-1];
            r_quo <= i_req.dividend[W-1] ? W'(-i_req.dividend) : W'(i_req.dividend);
            r_rem <= '0;
            r_den <= (i_req.divisor == '0) ? W'(1) : W'(i_req.divisor);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

// ===== src/lcc_point_mem.sv =====
// ---------------------------------------------------------------------------
// lcc_point_mem: point store
// One write and one registered read per cycle; holds x and y per point.
// ---------------------------------------------------------------------------
module lcc_point_mem (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [lcc_pkg::PADDR_W-1:0]             i_waddr,
    input  logic signed [lcc_pkg::COORD_WIDTH-1:0]  i_wx,
    input  logic signed [lcc_pkg::COORD_WIDTH-1:0]  i_wy,
    input  logic [lcc_pkg::PADDR_W-1:0]             i_raddr,
    output logic signed [lcc_pkg::COORD_WIDTH-1:0]  o_rx,
    output logic signed [lcc_pkg::COORD_WIDTH-1:0]  o_ry
);

    logic [2*lcc_pkg::COORD_WIDTH-1:0] r_mem [lcc_pkg::MAX_POINTS];
    logic [2*lcc_pkg::COORD_WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wx, i_wy};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rx = $signed(r_rd[2*lcc_pkg::COORD_WIDTH-1:lcc_pkg::COORD_WIDTH]);
    assign o_ry = $signed(r_rd[lcc_pkg::COORD_WIDTH-1:0]);

endmodule

// ===== src/lloyd_cluster_centers_2d.sv =====
// Loading: one point per cycle, start accepted whenever busy is low.
// After the last point: seeding, then per iteration assign and accumulate
// (one distance unit shared across centers) and the serial divider for each
// center's x and y; then k results, one per cycle.
// Results cannot be stalled. Synchronous active-low reset restores the register
// defaults and clears the point count and all center state.
// ---------------------------------------------------------------------------
// lloyd_cluster_centers_2d: k-means (Lloyd) clustering over a 2D point set
// Points sit in a single-port-read memory; centers, sums and counts in small
// register files. Labels are not stored: each point is accumulated right after
// its nearest center is found, which gives the same sums.
// ---------------------------------------------------------------------------
module lloyd_cluster_centers_2d (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [lcc_pkg::COORD_WIDTH-1:0]  i_point_x,
    input  logic signed [lcc_pkg::COORD_WIDTH-1:0]  i_point_y,
    input  logic                                    i_point_last,
    input  logic                                    i_cfg_we,
    input  logic [lcc_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [lcc_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    output logic                                    o_result_valid,
    output logic [lcc_pkg::CIDX_W-1:0]              o_cluster_index,
    output logic signed [lcc_pkg::COORD_WIDTH-1:0]  o_center_x,
    output logic signed [lcc_pkg::COORD_WIDTH-1:0]  o_center_y,
    output logic [lcc_pkg::PCNT_W-1:0]              o_member_count,
    output logic                                    o_result_last
);

    localparam int CW = lcc_pkg::COORD_WIDTH;
    localparam int SW = lcc_pkg::SUM_W;
    localparam int PW = lcc_pkg::PCNT_W;
    localparam int AW = lcc_pkg::PADDR_W;
    localparam int IW = lcc_pkg::CIDX_W;
    localparam int KW = lcc_pkg::CCNT_W;
    localparam int DW = lcc_pkg::DIST_W;

    lcc_pkg::t_state r_state, n_state;

    logic [4:0]           r_cfg_k;
    logic [7:0]           r_cfg_iter;
    logic [PW-1:0]        r_npts;
    logic [KW-1:0]        r_k;
    logic [7:0]           r_iter;
    logic [PW-1:0]        r_p;
    logic [IW:0]          r_c;
    logic                 r_phase;

    logic signed [CW-1:0] r_cx [lcc_pkg::MAX_CLUSTERS];
    logic signed [CW-1:0] r_cy [lcc_pkg::MAX_CLUSTERS];
    logic signed [SW-1:0] r_sx [lcc_pkg::MAX_CLUSTERS];
    logic signed [SW-1:0] r_sy [lcc_pkg::MAX_CLUSTERS];
    logic [PW-1:0]        r_cnt [lcc_pkg::MAX_CLUSTERS];

    logic [DW-1:0]        r_best;
    logic [IW-1:0]        r_bi;
    logic [CW:0]          r_dx, r_dy;
    logic                 r_dv;
    logic signed [SW-1:0] r_qx;

    logic                 w_accept;
    logic [AW-1:0]        w_raddr;
    logic signed [CW-1:0] w_px, w_py;
    logic [DW-1:0]        w_dist;
    logic [IW-1:0]        w_ci;
    logic                 w_div_done;
    logic signed [SW-1:0] w_quo;
    lcc_pkg::t_div_req    w_div_req;
    logic [KW-1:0]        w_kcfg;

    assign w_accept = start && !busy;
    assign busy     = (r_state != lcc_pkg::ST_LOAD);
    assign w_ci     = r_c[IW-1:0];

    always_comb begin
        if (r_cfg_k == 5'd0)
            w_kcfg = KW'(1);
        else if (r_cfg_k > 5'(lcc_pkg::MAX_CLUSTERS))
            w_kcfg = KW'(lcc_pkg::MAX_CLUSTERS);
        else
            w_kcfg = KW'(r_cfg_k);
    end

    always_comb begin
        priority case (r_state)
            lcc_pkg::ST_SEED:   w_raddr = AW'(r_c);
            default:            w_raddr = r_p[AW-1:0];
        endcase
    end

    lcc_point_mem u_pmem (
        .i_clk   (i_clk),
        .i_we    (w_accept && (r_npts < PW'(lcc_pkg::MAX_POINTS))),
        .i_waddr (r_npts[AW-1:0]),
        .i_wx    (i_point_x),
        .i_wy    (i_point_y),
        .i_raddr (w_raddr),
        .o_rx    (w_px),
        .o_ry    (w_py)
    );

    assign w_div_req.start    = (r_state == lcc_pkg::ST_DIV_X || r_state == lcc_pkg::ST_DIV_Y)
                                && !r_phase;
    assign w_div_req.dividend = (r_state == lcc_pkg::ST_DIV_X) ? r_sx[w_ci] : r_sy[w_ci];
    assign w_div_req.divisor  = r_cnt[w_ci];

    lcc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // squared distance of the registered abs differences; cannot overflow here
    assign w_dist = DW'(r_dx * r_dx) + DW'(r_dy * r_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcc_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcc_pkg::ST_LOAD:
                if (w_accept && i_point_last) n_state = lcc_pkg::ST_SEED;
            lcc_pkg::ST_SEED:
                if (r_c == (IW+1)'(r_k)) n_state = lcc_pkg::ST_ASSIGN;
            lcc_pkg::ST_ASSIGN:
                if (r_p == r_npts) n_state = lcc_pkg::ST_DIV_X;
                else if (r_phase && r_dv && r_c == (IW+1)'(r_k))
                    n_state = lcc_pkg::ST_ACCUM;
            lcc_pkg::ST_ACCUM:
                n_state = lcc_pkg::ST_ASSIGN;
            lcc_pkg::ST_DIV_X:
                if (r_phase && w_div_done) n_state = lcc_pkg::ST_DIV_Y;
            lcc_pkg::ST_DIV_Y:
                if (r_phase && w_div_done) n_state = lcc_pkg::ST_DIV_WRITE;
            lcc_pkg::ST_DIV_WAIT:
                n_state = lcc_pkg::ST_DIV_X;
            lcc_pkg::ST_DIV_WRITE:
                if ((r_c + 1'b1) != (IW+1)'(r_k)) n_state = lcc_pkg::ST_DIV_WAIT;
                else if (r_iter == 8'd1) n_state = lcc_pkg::ST_EMIT;
                else n_state = lcc_pkg::ST_ASSIGN;
            lcc_pkg::ST_EMIT:
                if ((r_c + 1'b1) == (IW+1)'(r_k)) n_state = lcc_pkg::ST_LOAD;
            default: n_state = lcc_pkg::ST_LOAD;
        endcase
    end

    // Assign walks p over points; per point: read (phase 0), then one center
    // per cycle through the abs-diff register, then add to the winner (ACCUM).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_k        <= 5'd2;
            r_cfg_iter     <= 8'd8;
            r_npts         <= '0;
            r_k            <= KW'(1);
            r_iter         <= 8'd1;
            r_p            <= '0;
            r_c            <= '0;
            r_phase        <= 1'b0;
            r_dv           <= 1'b0;
            o_result_valid <= 1'b0;
            for (int i = 0; i < lcc_pkg::MAX_CLUSTERS; i++) begin
                r_cx[i]  <= '0;
                r_cy[i]  <= '0;
                r_sx[i]  <= '0;
                r_sy[i]  <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            o_result_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == lcc_pkg::REG_CLUSTER_COUNT)
                    r_cfg_k <= i_cfg_data[4:0];
                else if (i_cfg_index == lcc_pkg::REG_ITERATION_COUNT)
                    r_cfg_iter <= i_cfg_data;
            end
            unique case (r_state)
                lcc_pkg::ST_LOAD: begin
                    if (w_accept) begin
                        if (r_npts < PW'(lcc_pkg::MAX_POINTS))
                            r_npts <= r_npts + 1'b1;
                        if (i_point_last) begin
                            r_k    <= w_kcfg;
                            r_iter <= (r_cfg_iter == 8'd0) ? 8'd1 : r_cfg_iter;
                            r_c    <= '0;
                            r_phase <= 1'b0;
                        end
                    end
                end
                lcc_pkg::ST_SEED: begin
                    // memory read of point c is registered and lands in the next cycle
                    r_phase <= 1'b1;
                    r_c     <= r_c + 1'b1;
                    if (r_phase) begin
                        if (PW'(r_c - 1'b1) < r_npts) begin
                            r_cx[r_c[IW-1:0] - 1'b1] <= w_px;
                            r_cy[r_c[IW-1:0] - 1'b1] <= w_py;
                        end else begin
                            r_cx[r_c[IW-1:0] - 1'b1] <= '0;
                            r_cy[r_c[IW-1:0] - 1'b1] <= '0;
                        end
                    end
                    if (r_c == (IW+1)'(r_k)) begin
                        r_p     <= '0;
                        r_c     <= '0;
                        r_phase <= 1'b0;
                        r_dv    <= 1'b0;
                        for (int i = 0; i < lcc_pkg::MAX_CLUSTERS; i++) begin
                            r_sx[i]  <= '0;
                            r_sy[i]  <= '0;
                            r_cnt[i] <= '0;
                        end
                    end
                end
                lcc_pkg::ST_ASSIGN: begin
                    if (r_p == r_npts) begin
                        r_c     <= '0;
                        r_phase <= 1'b0;
                    end else if (!r_phase) begin
                        r_phase <= 1'b1;
                        r_c     <= '0;
                        r_dv    <= 1'b0;
                    end else begin
                        if (r_c != (IW+1)'(r_k)) begin
                            r_dx <= (w_px >= r_cx[w_ci]) ? (CW+1)'(w_px - r_cx[w_ci])
                                                        : (CW+1)'(r_cx[w_ci] - w_px);
                            r_dy <= (w_py >= r_cy[w_ci]) ? (CW+1)'(w_py - r_cy[w_ci])
                                                        : (CW+1)'(r_cy[w_ci] - w_py);
                            r_c  <= r_c + 1'b1;
                        end
                        r_dv <= (r_c != (IW+1)'(r_k));
                        if (r_dv) begin
                            if (r_c == (IW+1)'(1) || w_dist < r_best) begin
                                r_best <= w_dist;
                                r_bi   <= w_ci - 1'b1;
                            end
                        end
                    end
                end
                lcc_pkg::ST_ACCUM: begin
                    r_sx[r_bi]  <= r_sx[r_bi] + SW'(w_px);
                    r_sy[r_bi]  <= r_sy[r_bi] + SW'(w_py);
                    r_cnt[r_bi] <= r_cnt[r_bi] + 1'b1;
                    r_p     <= r_p + 1'b1;
                    r_phase <= 1'b0;
                end
                lcc_pkg::ST_DIV_X: begin
                    r_phase <= 1'b1;
                    if (r_phase && w_div_done) begin
                        r_qx    <= w_quo;
                        r_phase <= 1'b0;
                    end
                end
                lcc_pkg::ST_DIV_Y: begin
                    r_phase <= 1'b1;
                    if (r_phase && w_div_done) begin
                        r_cx[w_ci] <= CW'(r_qx);
                        r_cy[w_ci] <= CW'(w_quo);
                        r_phase    <= 1'b0;
                    end
                end
                lcc_pkg::ST_DIV_WAIT: begin
                    r_phase <= 1'b0;
                end
                lcc_pkg::ST_DIV_WRITE: begin
                    r_phase <= 1'b0;
                    if ((r_c + 1'b1) != (IW+1)'(r_k)) begin
                        r_c <= r_c + 1'b1;
                    end else begin
                        r_c    <= '0;
                        r_p    <= '0;
                        r_dv   <= 1'b0;
                        if (r_iter != 8'd1) begin
                            r_iter <= r_iter - 1'b1;
                            for (int i = 0; i < lcc_pkg::MAX_CLUSTERS; i++) begin
                                r_sx[i]  <= '0;
                                r_sy[i]  <= '0;
                                r_cnt[i] <= '0;
                            end
                        end
                    end
                end
                lcc_pkg::ST_EMIT: begin
                    o_result_valid  <= 1'b1;
                    o_cluster_index <= w_ci;
                    o_center_x      <= r_cx[w_ci];
                    o_center_y      <= r_cy[w_ci];
                    o_member_count  <= r_cnt[w_ci];
                    o_result_last   <= ((r_c + 1'b1) == (IW+1)'(r_k));
                    r_c             <= r_c + 1'b1;
                    if ((r_c + 1'b1) == (IW+1)'(r_k))
                        r_npts <= '0;
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_result_while_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcc_pkg::ST_LOAD && $past(r_state) == lcc_pkg::ST_LOAD)
        |-> !o_result_valid)
        else $error("result outside emit");
    a_npts_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_npts <= PW'(lcc_pkg::MAX_POINTS))
        else $error("point count overflow");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_k != '0 && r_k <= KW'(lcc_pkg::MAX_CLUSTERS)))
        else $error("cluster count out of range");
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_last) |-> !busy)
        else $error("last result but still busy");
`endif

endmodule
